[sv/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define LRS_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Same check without a reset guard.
`define LRS_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

[sv/lrs_pkg.sv]
// Types and constants of the latency statistics block.
package lrs_pkg;

  localparam int unsigned DW = 64;
  localparam logic [32:0] COUNT_MAX    = 33'h1_FFFF_FFFF;
  localparam logic [32:0] FREEZE_LIMIT = 33'h0_FFFF_FFFF;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // One queued beat from the front to the back.
  typedef struct packed {
    logic        opcode;
    logic [31:0] elapsed;
  } lrs_item_t;

  // One result beat.
  typedef struct packed {
    logic [31:0] last_value;
    logic [31:0] first_value;
    logic [31:0] max_value;
    logic [31:0] min_value;
    logic [31:0] mean;
    logic [31:0] std_dev;
    logic [63:0] variance;
    logic        cold_report;
    logic        frozen;
  } lrs_result_t;

  // Request to an arithmetic unit.
  typedef struct packed {
    logic          start;
    logic [DW-1:0] op_a;
    logic [DW-1:0] op_b;
  } lrs_req_t;

  // Answer from an arithmetic unit.
  typedef struct packed {
    logic          done;
    logic [DW-1:0] value;
  } lrs_rsp_t;

endpackage

[sv/lrs_front.sv]
// Front end: input acceptance, enable filtering and a two-entry item queue.
module lrs_front
  import lrs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  logic      opcode,
  input  logic [31:0] elapsed,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data,
  output logic      q_valid,
  output lrs_item_t q_item,
  input  logic      q_pop
);

  lrs_item_t   slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;
  logic        enable;
  logic        take;
  logic        keep;

  assign cfg_ready = 1'b1;
  assign full      = (fill == 2'd2);
  assign take      = push && !full;
  // clears go through whenever the queue has room, records only while enabled
  assign keep      = take && ((opcode == OP_CLEAR) || enable);
  assign q_valid   = (fill != 2'd0);
  assign q_item    = slots[rd_ptr];

  // enable register
  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      enable <= cfg_data;
    end
  end

  // queue pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (keep) wr_ptr <= !wr_ptr;
      if (q_pop) rd_ptr <= !rd_ptr;
      fill <= fill + {1'b0, keep} - {1'b0, q_pop};
    end
  end

  // queue payload
  always_ff @(posedge clk) begin
    if (keep) begin
      slots[wr_ptr] <= '{opcode: opcode, elapsed: elapsed};
    end
  end

endmodule

[sv/lrs_mul.sv]
// Shift-add multiplier, 64-bit wrapping product, one multiplier bit a cycle.
module lrs_mul
  import lrs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  lrs_req_t req,
  output lrs_rsp_t rsp
);

  logic          busy;
  logic [DW-1:0] ma;
  logic [DW-1:0] mb;
  logic [DW-1:0] acc;

  // done once no multiplier bits remain
  assign rsp.done  = busy && (ma == '0);
  assign rsp.value = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
    end else if (rsp.done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      ma  <= req.op_a;
      mb  <= req.op_b;
      acc <= '0;
    end else if (busy && (ma != '0)) begin
      if (ma[0]) acc <= acc + mb;
      ma <= ma >> 1;
      mb <= mb << 1;
    end
  end

endmodule

[sv/lrs_div.sv]
// Restoring divider, 64 by 64 bits, one quotient bit a cycle.
module lrs_div
  import lrs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  lrs_req_t req,
  output lrs_rsp_t rsp
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [DW-1:0] quo;
  logic [DW-1:0] den;
  logic [DW:0]   trial;
  logic          fits;

  assign trial     = {rem, quo[DW-1]};
  assign fits      = (trial >= {1'b0, den});
  assign rsp.done  = busy && (cnt == '0);
  assign rsp.value = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
    end else if (rsp.done) begin
      busy <= 1'b0;
    end
  end

  // one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.op_a;
      den <= req.op_b;
      cnt <= CW'(DW);
    end else if (busy && (cnt != '0)) begin
      if (fits) begin
        rem <= DW'(trial - {1'b0, den});
      end else begin
        rem <= trial[DW-1:0];
      end
      quo <= {quo[DW-2:0], fits};
      cnt <= cnt - 1'b1;
    end
  end

endmodule

[sv/lrs_back.sv]
// Back end: statistics state, update sequencer and result register.
module lrs_back
  import lrs_pkg::*;
#(
  parameter int unsigned NEWTON_STEPS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  lrs_item_t   q_item,
  output logic        q_pop,
  output lrs_req_t    mul_req,
  input  lrs_rsp_t    mul_rsp,
  output lrs_req_t    div_req,
  input  lrs_rsp_t    div_rsp,
  output logic        res_valid,
  output lrs_result_t res,
  input  logic        res_pop
);

  localparam int unsigned SW = $clog2(NEWTON_STEPS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ   = 4'd1;
  localparam logic [3:0] S_NSQ  = 4'd2;
  localparam logic [3:0] S_SS   = 4'd3;
  localparam logic [3:0] S_DV1  = 4'd4;
  localparam logic [3:0] S_DV2  = 4'd5;
  localparam logic [3:0] S_AVG  = 4'd6;
  localparam logic [3:0] S_NDIV = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]    state;
  logic [32:0]   sample_count;
  logic [63:0]   sum_samples;
  logic [63:0]   sum_squares;
  logic [31:0]   last_sample;
  logic [31:0]   max_sample;
  logic [31:0]   min_sample;
  logic [31:0]   cold_sample;
  logic [31:0]   saved_mean;
  logic [31:0]   saved_root;
  logic [63:0]   saved_variance;
  logic [63:0]   nsq;
  logic [63:0]   var_work;
  logic [63:0]   x;
  logic [SW-1:0] steps;
  logic          is_cold;
  logic          is_frozen;
  logic [32:0]   count_next;
  logic [31:0]   d;
  logic [63:0]   xn;
  logic          go_on;
  logic          out_free;
  logic          mul_start;
  logic [63:0]   mul_a;
  logic [63:0]   mul_b;
  logic          div_start;
  logic [63:0]   div_a;
  logic [63:0]   div_b;
  logic          rec_go;
  logic          avg_go;
  logic          newton_go;
  logic          mul_go;
  logic          div_go;

  assign d          = q_item.elapsed;
  assign count_next = (sample_count < COUNT_MAX) ? sample_count + 33'd1 : sample_count;
  assign q_pop      = (state == S_IDLE) && q_valid;
  assign xn         = 64'(div_rsp.value + x) >> 1;
  assign go_on      = (steps < SW'(NEWTON_STEPS)) && (xn != x);
  assign out_free   = !res_valid || res_pop;

  assign mul_req = '{start: mul_start, op_a: mul_a, op_b: mul_b};
  assign div_req = '{start: div_start, op_a: div_a, op_b: div_b};

  // arithmetic unit launches
  assign rec_go    = (state == S_IDLE) && q_valid && (q_item.opcode == OP_RECORD) &&
                     (count_next != 33'd1) && !(count_next > FREEZE_LIMIT);
  assign avg_go    = (state == S_AVG) && div_rsp.done && (var_work != '0) &&
                     (div_rsp.value[31:0] != '0);
  assign newton_go = (state == S_NDIV) && div_rsp.done && go_on && (xn != '0);
  assign mul_go    = rec_go || (((state == S_SQ) || (state == S_NSQ)) && mul_rsp.done);
  assign div_go    = ((state == S_SS) && mul_rsp.done) ||
                     (((state == S_DV1) || (state == S_DV2)) && div_rsp.done) ||
                     avg_go || newton_go;

  // start pulses
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_start <= 1'b0;
      div_start <= 1'b0;
    end else begin
      mul_start <= mul_go;
      div_start <= div_go;
    end
  end

  // sequencer and statistics state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      sample_count   <= '0;
      sum_samples    <= '0;
      sum_squares    <= '0;
      last_sample    <= '0;
      max_sample     <= '0;
      min_sample     <= '0;
      cold_sample    <= '0;
      saved_mean     <= '0;
      saved_root     <= '0;
      saved_variance <= '0;
      is_cold        <= 1'b0;
      is_frozen      <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_item.opcode == OP_CLEAR) begin
              sample_count   <= '0;
              sum_samples    <= '0;
              sum_squares    <= '0;
              last_sample    <= '0;
              max_sample     <= '0;
              min_sample     <= '0;
              cold_sample    <= '0;
              saved_mean     <= '0;
              saved_root     <= '0;
              saved_variance <= '0;
            end else begin
              sample_count <= count_next;
              is_cold      <= (count_next == 33'd1);
              is_frozen    <= (count_next > FREEZE_LIMIT);
              if (count_next == 33'd1) begin
                cold_sample <= d;
                state       <= S_OUT;
              end else begin
                last_sample <= d;
                if (d > max_sample) max_sample <= d;
                if ((min_sample == '0) || (d < min_sample)) min_sample <= d;
                if (count_next > FREEZE_LIMIT) begin
                  state <= S_OUT;
                end else begin
                  sum_samples <= sum_samples + {32'd0, d};
                  mul_a       <= {32'd0, d};
                  mul_b       <= {32'd0, d};
                  state       <= S_SQ;
                end
              end
            end
          end
        end
        S_SQ: begin
          if (mul_rsp.done) begin
            sum_squares <= sum_squares + mul_rsp.value;
            mul_a       <= {31'd0, sample_count};
            mul_b       <= sum_squares + mul_rsp.value;
            state       <= S_NSQ;
          end
        end
        S_NSQ: begin
          if (mul_rsp.done) begin
            nsq   <= mul_rsp.value;
            mul_a <= sum_samples;
            mul_b <= sum_samples;
            state <= S_SS;
          end
        end
        S_SS: begin
          if (mul_rsp.done) begin
            div_a <= nsq - mul_rsp.value;
            div_b <= {32'd0, sample_count[31:0]};
            state <= S_DV1;
          end
        end
        S_DV1: begin
          if (div_rsp.done) begin
            div_a <= div_rsp.value;
            div_b <= {32'd0, sample_count[31:0] - 32'd1};
            state <= S_DV2;
          end
        end
        S_DV2: begin
          if (div_rsp.done) begin
            var_work <= div_rsp.value;
            div_a    <= sum_samples;
            div_b    <= {31'd0, sample_count};
            state    <= S_AVG;
          end
        end
        S_AVG: begin
          if (div_rsp.done) begin
            saved_mean     <= div_rsp.value[31:0];
            saved_variance <= var_work;
            x              <= {32'd0, div_rsp.value[31:0]};
            steps          <= '0;
            if (var_work == '0) begin
              saved_root <= '0;
              state      <= S_OUT;
            end else if (div_rsp.value[31:0] == '0) begin
              // zero seed: the root falls back to the variance
              saved_root <= var_work[31:0];
              state      <= S_OUT;
            end else begin
              div_a <= var_work;
              div_b <= {32'd0, div_rsp.value[31:0]};
              state <= S_NDIV;
            end
          end
        end
        S_NDIV: begin
          if (div_rsp.done) begin
            x     <= xn;
            steps <= steps + 1'b1;
            if (!go_on) begin
              saved_root <= xn[31:0];
              state      <= S_OUT;
            end else if (xn == '0) begin
              saved_root <= var_work[31:0];
              state      <= S_OUT;
            end else begin
              div_a <= var_work;
              div_b <= xn;
              state <= S_NDIV;
            end
          end
        end
        S_OUT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((state == S_OUT) && out_free) begin
      res_valid <= 1'b1;
    end else if (res_pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && out_free) begin
      if (is_cold) begin
        res <= '{last_value: '0, first_value: cold_sample, max_value: '0,
                 min_value: '0, mean: '0, std_dev: '0, variance: '0,
                 cold_report: 1'b1, frozen: 1'b0};
      end else begin
        res <= '{last_value: last_sample, first_value: cold_sample,
                 max_value: max_sample, min_value: min_sample, mean: saved_mean,
                 std_dev: saved_root, variance: saved_variance,
                 cold_report: 1'b0, frozen: is_frozen};
      end
    end
  end

endmodule

[sv/latency_running_statistics.sv]
// Top level of the latency running statistics block.
//
//   channel   direction  handshake               beat
//   input     in         push / full             opcode, elapsed
//   result    out        empty / pop             nine statistics fields
//   config    in         cfg_valid / cfg_ready   cfg_data (enable)
//
// While cold or frozen, a recorded sample goes straight from the back end's idle
// state to its output state; otherwise it takes three products in the shift-add
// multiplier (32-, 33- and 64-bit multiplier operands) and up to NEWTON_STEPS+4
// passes through the shared divider. A clear is handled in the idle state alone.
// Reset is synchronous, needs no sweep. A two-entry queue lets input beats land
// while the back end works or a result waits to be popped.
module latency_running_statistics
  import lrs_pkg::*;
#(
  parameter int unsigned NEWTON_STEPS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        opcode,
  input  logic [31:0] elapsed,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] last_value,
  output logic [31:0] first_value,
  output logic [31:0] max_value,
  output logic [31:0] min_value,
  output logic [31:0] mean,
  output logic [31:0] std_dev,
  output logic [63:0] variance,
  output logic        cold_report,
  output logic        frozen,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  logic        q_valid;
  lrs_item_t   q_item;
  logic        q_pop;
  lrs_req_t    mul_req;
  lrs_rsp_t    mul_rsp;
  lrs_req_t    div_req;
  lrs_rsp_t    div_rsp;
  logic        res_valid;
  lrs_result_t res;

  lrs_front u_front (
    .clk, .rst, .push, .full, .opcode, .elapsed,
    .cfg_valid, .cfg_ready, .cfg_data,
    .q_valid, .q_item, .q_pop
  );

  lrs_mul u_mul (.clk, .rst, .req(mul_req), .rsp(mul_rsp));
  lrs_div u_div (.clk, .rst, .req(div_req), .rsp(div_rsp));

  lrs_back #(.NEWTON_STEPS(NEWTON_STEPS)) u_back (
    .clk, .rst, .q_valid, .q_item, .q_pop,
    .mul_req, .mul_rsp, .div_req, .div_rsp,
    .res_valid, .res, .res_pop(pop && !empty)
  );

  // result ports
  assign empty       = !res_valid;
  assign last_value  = res.last_value;
  assign first_value = res.first_value;
  assign max_value   = res.max_value;
  assign min_value   = res.min_value;
  assign mean        = res.mean;
  assign std_dev     = res.std_dev;
  assign variance    = res.variance;
  assign cold_report = res.cold_report;
  assign frozen      = res.frozen;

endmodule

[sv/lrs_checker.sv]
// Port-level checker for the latency statistics block, bound to the top level.
`include "assert_macros.svh"

module lrs_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [31:0] last_value,
  input logic [31:0] max_value,
  input logic [31:0] min_value,
  input logic [31:0] mean,
  input logic [31:0] std_dev,
  input logic [63:0] variance,
  input logic        cold_report,
  input logic        frozen
);

  // a cold beat carries only the first sample
  `LRS_ASSERT(a_cold_zero, clk, rst, (!empty && cold_report) |-> (last_value == '0 && max_value == '0 && mean == '0 && std_dev == '0 && variance == '0), "cold beat has nonzero stats")
  // cold and frozen exclude each other
  `LRS_ASSERT(a_cold_frozen, clk, rst, !empty |-> !(cold_report && frozen), "cold and frozen together")
  // min never exceeds max on a regular beat
  `LRS_ASSERT(a_min_max, clk, rst, (!empty && !cold_report) |-> (min_value <= max_value), "min above max")
  // a stalled beat holds
  `LRS_ASSERT(a_hold, clk, rst, (!empty && !pop) |=> (!empty && $stable(last_value) && $stable(variance)), "stalled beat changed")

endmodule

bind latency_running_statistics lrs_checker u_lrs_checker (
  .clk, .rst, .empty, .pop, .last_value, .max_value, .min_value,
  .mean, .std_dev, .variance, .cold_report, .frozen
);
